// ===== rtl/assert_macros.svh =====
// Assertion helpers used by sds_ctrl; empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SDS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define SDS_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define SDS_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define SDS_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/sds_pkg.sv =====
package sds_pkg;

    localparam int unsigned MAX_STATIONS_DEF = 32;
    localparam int unsigned TRACE_LEN_DEF    = 1024;
    localparam int unsigned MAX_CELLS_DEF    = 256;
    localparam int unsigned WINDOW_DEF       = 256;

    localparam int SMP_W = 32;
    localparam int STK_W = 48;
    localparam int WGT_W = 17;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [WGT_W-1:0] WGT_ONE = 17'd65536;
    localparam logic [24:0] ONE24  = 25'd16777216;
    localparam logic [48:0] HALF24 = 49'd8388608;
    localparam int unsigned EXP_STEPS = 12;
    // S-phase cutoff: 100*tt > 168*cutoff
    localparam logic [39:0] S_CUT_NUM = 40'd168;
    localparam logic [39:0] S_CUT_DEN = 40'd100;

    typedef enum logic [2:0] {
        REQ_LOAD   = 3'd0,
        REQ_STACK  = 3'd1,
        REQ_READ   = 3'd2,
        REQ_DETECT = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        CFG_ATTEN  = 3'd0,
        CFG_NST    = 3'd1,
        CFG_NCELL  = 3'd2,
        CFG_PRE    = 3'd3,
        CFG_WLEN   = 3'd4,
        CFG_CUTOFF = 3'd5,
        CFG_RECIP  = 3'd6
    } t_cfg;

    typedef enum logic [1:0] {
        ATT_CUT  = 2'd0,
        ATT_EXP  = 2'd1,
        ATT_NONE = 2'd2
    } t_att;

    typedef enum logic [1:0] {
        STS_OK  = 2'd0,
        STS_OOR = 2'd1,
        STS_SAT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WEIGHT,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        W_IDLE,
        W_ITER,
        W_FIN
    } t_wstate;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic wgt_start;
        logic run_init;
        logic issue;
        logic rd_issue;
        logic clear_all;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       stack_go;
        logic       detect_go;
        logic       wgt_done;
        logic       issue_last;
        logic       pipe_idle;
        logic       out_free;
    } t_stat;

    // exp(-2^(i-8)) in Q0.24
    function automatic logic [23:0] exp_rom(input logic [3:0] i);
        logic [23:0] v;
        case (i)
            4'd0:    v = 24'd16711808;
            4'd1:    v = 24'd16646655;
            4'd2:    v = 24'd16517109;
            4'd3:    v = 24'd16261035;
            4'd4:    v = 24'd15760736;
            4'd5:    v = 24'd14805841;
            4'd6:    v = 24'd13066109;
            4'd7:    v = 24'd10175896;
            4'd8:    v = 24'd6171993;
            4'd9:    v = 24'd2270549;
            4'd10:   v = 24'd307285;
            4'd11:   v = 24'd5628;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/sds_req_if.sv =====
interface sds_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [4:0]         station;
    logic [9:0]         sample_index;
    logic signed [31:0] sample_value;
    logic [7:0]         cell_req;
    logic signed [15:0] travel_time;
    logic [7:0]         time_index;

    modport source(output valid, req_type, station, sample_index, sample_value,
                   cell_req, travel_time, time_index, input ready);
    modport sink(input valid, req_type, station, sample_index, sample_value,
                 cell_req, travel_time, time_index, output ready);
endinterface

// ===== rtl/sds_res_if.sv =====
interface sds_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [47:0] value;
    logic [7:0]         best_cell;

    modport source(output valid, status, value, best_cell, input ready);
    modport sink(input valid, status, value, best_cell, output ready);
endinterface

// ===== rtl/sds_wgt.sv =====
module sds_wgt import sds_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_mode,
    input  logic [14:0]      i_tt,
    input  logic             i_s_phase,
    input  logic [31:0]      i_cutoff,
    input  logic [31:0]      i_recip,
    output logic             o_done,
    output logic [WGT_W-1:0] o_w
);

    t_wstate     r_state, n_state;
    logic [46:0] r_prod;
    logic [24:0] r_acc;
    logic [3:0]  r_i;
    logic        r_cut;
    logic [11:0] x;
    logic        big;

    assign x   = r_prod[35:24];
    assign big = |r_prod[46:36];

    always_comb begin
        n_state = r_state;
        case (r_state)
            W_IDLE: begin
                if (i_start) begin
                    n_state = (i_mode == ATT_EXP) ? W_ITER : W_FIN;
                end
            end
            W_ITER: begin
                if (r_i == 4'(EXP_STEPS - 1)) begin
                    n_state = W_FIN;
                end
            end
            W_FIN:   n_state = W_IDLE;
            default: n_state = W_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == W_FIN);
        case (i_mode)
            ATT_CUT: o_w = r_cut ? '0 : WGT_ONE;
            ATT_EXP: o_w = big ? '0 : WGT_W'((26'(r_acc) + 26'd128) >> 8);
            default: o_w = WGT_ONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == W_IDLE && i_start) begin
            r_prod <= 47'(i_tt) * 47'(i_recip);
            r_cut  <= i_s_phase ? (40'(i_tt) * S_CUT_DEN > 40'(i_cutoff) * S_CUT_NUM)
                                : (32'(i_tt) > i_cutoff);
            r_acc  <= ONE24;
            r_i    <= '0;
        end else if (r_state == W_ITER) begin
            if (x[r_i]) begin
                r_acc <= 25'((49'(r_acc) * 49'(exp_rom(r_i)) + HALF24) >> 24);
            end
            r_i <= r_i + 4'd1;
        end
    end

endmodule

// ===== rtl/sds_dp.sv =====
module sds_dp import sds_pkg::*; #(
    parameter int unsigned MAX_STATIONS = MAX_STATIONS_DEF,
    parameter int unsigned TRACE_LEN    = TRACE_LEN_DEF,
    parameter int unsigned MAX_CELLS    = MAX_CELLS_DEF,
    parameter int unsigned WINDOW       = WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [2:0]           i_req_type,
    input  logic [4:0]           i_station,
    input  logic [9:0]           i_sample_index,
    input  logic signed [31:0]   i_sample_value,
    input  logic [7:0]           i_cell_req,
    input  logic signed [15:0]   i_travel_time,
    input  logic [7:0]           i_time_index,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [1:0]           o_status,
    output logic signed [47:0]   o_value,
    output logic [7:0]           o_best_cell
);

    localparam int unsigned TDEPTH = MAX_STATIONS * TRACE_LEN;
    localparam int TA_W  = $clog2(TDEPTH);
    localparam int unsigned SDEPTH = MAX_CELLS * WINDOW;
    localparam int SA_W  = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int CV_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CW_W  = $clog2(WINDOW + 1);
    localparam int CC_W  = $clog2(MAX_CELLS + 1);
    localparam int CNT_W = (CW_W > CC_W) ? CW_W : CC_W;
    localparam int POS_W = 17 + CNT_W;

    // configuration
    logic [1:0]  r_mode;
    logic [5:0]  r_nst;
    logic [8:0]  r_ncell;
    logic [9:0]  r_pre;
    logic [8:0]  r_wlen;
    logic [31:0] r_cutoff;
    logic [31:0] r_recip;

    // captured request
    logic [2:0]         r_req;
    logic [4:0]         r_st;
    logic [9:0]         r_sidx;
    logic signed [31:0] r_sval;
    logic [7:0]         r_cell;
    logic [14:0]        r_tt;
    logic [7:0]         r_tidx;

    logic [STK_W-1:0] smem [SDEPTH];
    logic [SMP_W-1:0] tmem [TDEPTH];
    logic             r_row_v [MAX_CELLS];

    logic [CNT_W-1:0] r_cnt, r_end;
    logic             r_rowv;
    logic [WGT_W-1:0] r_w;

    logic                  p1_v, p1_add, p1_oor, p1_rowv;
    logic [SA_W-1:0]       p1_addr;
    logic [CNT_W-1:0]      p1_idx;
    logic [STK_W-1:0]      r_srd;
    logic signed [SMP_W-1:0] r_trd;

    logic                  p2_v, p2_add, p2_oor;
    logic [SA_W-1:0]       p2_addr;
    logic signed [STK_W-1:0] p2_old;
    logic signed [49:0]    p2_prod;

    logic signed [STK_W-1:0] r_val;
    logic [CNT_W-1:0]      r_best;
    logic                  r_sat, r_oor;

    logic                  r_ov;
    logic [1:0]            r_ostat;
    logic signed [47:0]    r_oval;
    logic [7:0]            r_obest;

    logic             load_ok, stack_go, s_phase, tidx_ok, cell_ok, detect_go;
    logic             is_stack, issue_eff, rd_addr_ok, run_last;
    logic [CNT_W-1:0] wl, nc;
    logic [CV_W-1:0]  cell_ix;
    logic [POS_W-1:0] pos;
    logic             oor, add;
    logic [SA_W-1:0]  s_addr;
    logic [TA_W-1:0]  t_addr;
    logic             rowv0;
    logic signed [STK_W-1:0] old1;
    logic signed [33:0] term;
    logic signed [49:0] sum;
    logic signed [STK_W-1:0] sum_sat;
    logic             sat_now;
    logic             wgt_done;
    logic [WGT_W-1:0] wgt;
    logic [1:0]       fin_stat;

    sds_wgt u_wgt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.wgt_start),
        .i_mode    (r_mode),
        .i_tt      (r_tt),
        .i_s_phase (s_phase),
        .i_cutoff  (r_cutoff),
        .i_recip   (r_recip),
        .o_done    (wgt_done),
        .o_w       (wgt)
    );

    always_comb begin
        load_ok   = (32'(r_st) < 32'(MAX_STATIONS)) && (32'(r_sidx) < 32'(TRACE_LEN));
        stack_go  = ({1'b0, r_st} < r_nst) && (32'(r_st) < 32'(MAX_STATIONS))
                    && (32'(r_cell) < 32'(MAX_CELLS));
        s_phase   = {1'b0, r_st} >= (r_nst >> 1);
        wl        = (32'(r_wlen) > 32'(WINDOW)) ? CNT_W'(WINDOW) : CNT_W'(r_wlen);
        nc        = (32'(r_ncell) > 32'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(r_ncell);
        tidx_ok   = 32'(r_tidx) < 32'(WINDOW);
        cell_ok   = 32'(r_cell) < 32'(MAX_CELLS);
        detect_go = tidx_ok && (nc != '0);
        cell_ix   = cell_ok ? CV_W'(r_cell) : '0;
        is_stack  = (r_req == REQ_STACK);
        run_last  = (r_end == '0) || (r_cnt == r_end - CNT_W'(1));
        issue_eff = i_cmd.issue && (r_cnt != r_end);
        rd_addr_ok = cell_ok && tidx_ok;

        pos = POS_W'(r_pre) + POS_W'(r_tt) + POS_W'(r_cnt);
        add = r_cnt < wl;
        oor = 32'(pos) >= 32'(TRACE_LEN);
        t_addr = oor ? '0 : TA_W'(32'(r_st) * 32'(TRACE_LEN) + 32'(pos));

        if (i_cmd.rd_issue) begin
            s_addr = rd_addr_ok ? SA_W'(32'(r_cell) * 32'(WINDOW) + 32'(r_tidx)) : '0;
            rowv0  = rd_addr_ok && r_row_v[cell_ix];
        end else if (is_stack) begin
            s_addr = SA_W'(32'(r_cell) * 32'(WINDOW) + 32'(r_cnt));
            rowv0  = r_rowv;
        end else begin
            s_addr = SA_W'(32'(r_cnt) * 32'(WINDOW) + 32'(r_tidx));
            rowv0  = r_row_v[CV_W'(r_cnt)];
        end

        old1 = p1_rowv ? $signed(r_srd) : '0;

        term = 34'((p2_prod + 50'sd32768) >>> 16);
        sum  = 50'(p2_old) + ((p2_add && !p2_oor) ? 50'(term) : 50'sd0);
        sat_now = 1'b0;
        sum_sat = sum[STK_W-1:0];
        if (sum > 50'sd140737488355327) begin
            sum_sat = {1'b0, {(STK_W-1){1'b1}}};
            sat_now = 1'b1;
        end else if (sum < -50'sd140737488355328) begin
            sum_sat = {1'b1, {(STK_W-1){1'b0}}};
            sat_now = 1'b1;
        end

        case (r_req)
            REQ_LOAD:  fin_stat = load_ok ? STS_OK : STS_OOR;
            REQ_STACK: fin_stat = r_sat ? STS_SAT : (r_oor ? STS_OOR : STS_OK);
            default:   fin_stat = STS_OK;
        endcase

        o_stat.req        = r_req;
        o_stat.stack_go   = stack_go;
        o_stat.detect_go  = detect_go;
        o_stat.wgt_done   = wgt_done;
        o_stat.issue_last = run_last;
        o_stat.pipe_idle  = !p1_v && !p2_v;
        o_stat.out_free   = !r_ov || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ATT_NONE;
            r_nst    <= 6'd2;
            r_ncell  <= 9'd1;
            r_pre    <= '0;
            r_wlen   <= 9'd1;
            r_cutoff <= '0;
            r_recip  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ATTEN:  r_mode   <= i_cfg_data[1:0];
                CFG_NST:    r_nst    <= i_cfg_data[5:0];
                CFG_NCELL:  r_ncell  <= i_cfg_data[8:0];
                CFG_PRE:    r_pre    <= i_cfg_data[9:0];
                CFG_WLEN:   r_wlen   <= i_cfg_data[8:0];
                CFG_CUTOFF: r_cutoff <= i_cfg_data;
                CFG_RECIP:  r_recip  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_type;
            r_st   <= i_station;
            r_sidx <= i_sample_index;
            r_sval <= i_sample_value;
            r_cell <= i_cell_req;
            r_tt   <= i_travel_time[15] ? '0 : i_travel_time[14:0];
            r_tidx <= i_time_index;
        end
        if (wgt_done) begin
            r_w <= wgt;
        end
    end

    // per-cell valid bits: a cell never stacked since reset or clear reads zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            for (int c = 0; c < int'(MAX_CELLS); c++) begin
                r_row_v[c] <= 1'b0;
            end
        end else if (i_cmd.run_init && is_stack) begin
            r_row_v[cell_ix] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            r_cnt  <= '0;
            r_rowv <= r_row_v[cell_ix];
            if (is_stack) begin
                // first stack into a cell rewrites the whole row
                r_end <= r_row_v[cell_ix] ? wl : CNT_W'(WINDOW);
            end else begin
                r_end <= nc;
            end
        end else if (issue_eff) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok && i_cmd.load_wr) begin
            tmem[TA_W'(32'(r_st) * 32'(TRACE_LEN) + 32'(r_sidx))] <= r_sval;
        end
        r_trd <= $signed(tmem[t_addr]);
    end

    always_ff @(posedge i_clk) begin
        if (p2_v) begin
            smem[p2_addr] <= sum_sat;
        end
        r_srd <= smem[s_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            p1_v <= 1'b0;
            p2_v <= 1'b0;
        end else begin
            p1_v <= issue_eff || i_cmd.rd_issue;
            p2_v <= p1_v && is_stack;
        end
    end

    always_ff @(posedge i_clk) begin
        p1_addr <= s_addr;
        p1_add  <= add;
        p1_oor  <= oor && add;
        p1_rowv <= rowv0;
        p1_idx  <= r_cnt;
        p2_addr <= p1_addr;
        p2_add  <= p1_add;
        p2_oor  <= p1_oor;
        p2_old  <= old1;
        p2_prod <= r_trd * $signed({1'b0, r_w});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_val  <= '0;
            r_best <= '0;
            r_sat  <= 1'b0;
            r_oor  <= 1'b0;
        end else begin
            if (p1_v && r_req == REQ_DETECT && old1 > r_val) begin
                r_val  <= old1;
                r_best <= p1_idx;
            end else if (p1_v && r_req == REQ_READ) begin
                r_val <= old1;
            end
            if (p2_v) begin
                r_sat <= r_sat | sat_now;
                r_oor <= r_oor | p2_oor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ostat <= fin_stat;
            r_oval  <= (r_req == REQ_READ || r_req == REQ_DETECT) ? r_val : '0;
            r_obest <= (r_req == REQ_DETECT) ? 8'(r_best) : '0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_ostat;
    assign o_value     = r_oval;
    assign o_best_cell = r_obest;

endmodule

// ===== rtl/sds_ctrl.sv =====
`include "assert_macros.svh"
module sds_ctrl import sds_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.req)
                    REQ_STACK:  n_state = i_stat.stack_go ? S_WEIGHT : S_DONE;
                    REQ_READ:   n_state = S_DRAIN;
                    REQ_DETECT: n_state = i_stat.detect_go ? S_RUN : S_DONE;
                    default:    n_state = S_DONE;
                endcase
            end
            S_WEIGHT: begin
                if (i_stat.wgt_done) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_stat.issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_idle) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: o_cmd.capture = i_in_valid;
            S_DECODE: begin
                case (i_stat.req)
                    REQ_LOAD:   o_cmd.load_wr   = 1'b1;
                    REQ_STACK:  o_cmd.wgt_start = i_stat.stack_go;
                    REQ_READ:   o_cmd.rd_issue  = 1'b1;
                    REQ_DETECT: o_cmd.run_init  = i_stat.detect_go;
                    REQ_CLEAR:  o_cmd.clear_all = 1'b1;
                    default: ;
                endcase
            end
            S_WEIGHT: o_cmd.run_init = i_stat.wgt_done;
            S_RUN:    o_cmd.issue    = 1'b1;
            S_DONE:   o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SDS_ASSERT_IMP(a_idle_pipe_empty, i_clk, i_rst_n, r_state == S_IDLE, i_stat.pipe_idle)
    `SDS_ASSERT_NXT(a_result_then_idle, i_clk, i_rst_n, o_cmd.out_load, r_state == S_IDLE)
    `SDS_ASSERT_IMP(a_no_issue_on_capture, i_clk, i_rst_n, o_cmd.capture,
        !o_cmd.issue && !o_cmd.out_load && !o_cmd.rd_issue)

endmodule

// ===== rtl/seismic_delay_sum_stacker.sv =====
// Channel   Dir  Beat contents
// i_req_ch  in   req_type, station, sample_index, sample_value, cell_req,
//                travel_time, time_index
// o_res_ch  out  status, value, best_cell
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// One request at a time. Load, clear, reject: decode, done. Read: decode, drain, done.
// Stack: weight (iterated in exp mode) then one stack read-modify-write per
// cycle over window_len samples (whole row on the first stack into a cell after
// reset or clear), plus decode and a pipeline drain.
// Detect walks num_cells rows at one per cycle, then drains the pipeline.
// Reset needs no sweep: per-cell valid bits make untouched stacks read zero.
// A result held in the output register stalls only the next result, not acceptance.
module seismic_delay_sum_stacker import sds_pkg::*; #(
    parameter int unsigned MAX_STATIONS = MAX_STATIONS_DEF,
    parameter int unsigned TRACE_LEN    = TRACE_LEN_DEF,
    parameter int unsigned MAX_CELLS    = MAX_CELLS_DEF,
    parameter int unsigned WINDOW       = WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sds_req_if.sink              i_req_ch,
    sds_res_if.source            o_res_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    sds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req_ch.valid),
        .o_in_ready (i_req_ch.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sds_dp #(
        .MAX_STATIONS (MAX_STATIONS),
        .TRACE_LEN    (TRACE_LEN),
        .MAX_CELLS    (MAX_CELLS),
        .WINDOW       (WINDOW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_ch.req_type),
        .i_station      (i_req_ch.station),
        .i_sample_index (i_req_ch.sample_index),
        .i_sample_value (i_req_ch.sample_value),
        .i_cell_req     (i_req_ch.cell_req),
        .i_travel_time  (i_req_ch.travel_time),
        .i_time_index   (i_req_ch.time_index),
        .i_out_ready    (o_res_ch.ready),
        .o_out_valid    (o_res_ch.valid),
        .o_status       (o_res_ch.status),
        .o_value        (o_res_ch.value),
        .o_best_cell    (o_res_ch.best_cell)
    );

endmodule
